/* hdl/qrrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrrs_pkg - shared types and GF(256) helpers for the QR Reed-Solomon encoder
// Field polynomial 0x11D, generator table built at elaboration.
// ----------------------------------------------------------------------------
package qrrs_pkg;

	// Largest check-byte count the generator table covers
	localparam int GEN_MAX = 64;
	localparam int GEN_IW = 7;

	// Low byte of the field polynomial x^8+x^4+x^3+x^2+1
	localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;

	// Reset value of the check-byte count register
	localparam logic [4:0] ECC_COUNT_RST = 5'd10;

	// Register index of ecc_count
	localparam logic REG_ECC_COUNT = 1'b0;

	typedef logic [7:0] gf_t;
	typedef logic [GEN_MAX:0][7:0] gen_row_t;
	typedef gen_row_t [GEN_MAX:0] gen_tbl_t;

	// Shift-and-add GF(256) multiply
	function automatic gf_t gf_mul(gf_t a, gf_t b);
		gf_t x;
		gf_t acc;
		x = a;
		acc = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LOW : 8'h00);
		end
		return acc;
	endfunction

	// Row n: coefficients of prod (x + alpha^i), i < n, entry j is x^j
	function automatic gen_tbl_t gen_table();
		gen_tbl_t tbl;
		gen_row_t g;
		gf_t root;
		tbl = '0;
		g = '0;
		g[0] = 8'h01;
		root = 8'h01;
		tbl[0] = g;
		for (int n = 1; n <= GEN_MAX; n++) begin
			g[n] = g[n-1];
			for (int j = n - 1; j > 0; j--) begin
				g[j] = g[j-1] ^ gf_mul(g[j], root);
			end
			g[0] = gf_mul(g[0], root);
			root = gf_mul(root, 8'h02);
			tbl[n] = g;
		end
		return tbl;
	endfunction

endpackage

/* hdl/qrrs_cfg.sv */
// ----------------------------------------------------------------------------
// qrrs_cfg - configuration register and generator row select
// Holds ecc_count, its saturated value and the matching generator row.
// ----------------------------------------------------------------------------
module qrrs_cfg #(
	parameter int MAX_ECC = 30,
	localparam int CW = $clog2(MAX_ECC + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [CW-1:0]               nact,
	output qrrs_pkg::gf_t               gen_row [MAX_ECC]
);

	localparam qrrs_pkg::gen_tbl_t GEN_TBL = qrrs_pkg::gen_table();

	logic [4:0]     ecc_q;
	logic [CW-1:0]  nact_q;
	qrrs_pkg::gf_t  gen_q [MAX_ECC];
	logic           wr_en;
	logic [CW-1:0]  wr_sat;
	logic [CW-1:0]  rst_sat;

	// Clamp the count into 2..MAX_ECC
	function automatic logic [CW-1:0] sat_cnt(logic [4:0] v);
		int n;
		n = int'(v);
		if (n < 2) begin
			n = 2;
		end
		if (n > MAX_ECC) begin
			n = MAX_ECC;
		end
		return CW'(n);
	endfunction

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready && (paddr[2] == qrrs_pkg::REG_ECC_COUNT);
	assign wr_sat = sat_cnt(pwdata[4:0]);
	assign rst_sat = sat_cnt(qrrs_pkg::ECC_COUNT_RST);

	// Count register; generator row follows at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q <= qrrs_pkg::ECC_COUNT_RST;
			nact_q <= rst_sat;
			for (int j = 0; j < MAX_ECC; j++) begin
				gen_q[j] <= GEN_TBL[qrrs_pkg::GEN_IW'(rst_sat)][j];
			end
		end else if (wr_en) begin
			ecc_q <= pwdata[4:0];
			nact_q <= wr_sat;
			for (int j = 0; j < MAX_ECC; j++) begin
				gen_q[j] <= GEN_TBL[qrrs_pkg::GEN_IW'(wr_sat)][j];
			end
		end
	end

	// Read back
	always_comb begin
		if (paddr[2] == qrrs_pkg::REG_ECC_COUNT) begin
			prdata = {27'd0, ecc_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign nact = nact_q;
	assign gen_row = gen_q;

endmodule

/* hdl/qrrs_lfsr.sv */
// ----------------------------------------------------------------------------
// qrrs_lfsr - input stage and remainder register
// One data beat per cycle divides into the remainder unless a last beat waits on
// the busy drain buffer; a last beat hands the remainder over and clears it.
// ----------------------------------------------------------------------------
module qrrs_lfsr #(
	parameter int MAX_ECC = 30,
	localparam int CW = $clog2(MAX_ECC + 1),
	localparam int IW = $clog2(MAX_ECC)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tlast,
	input  logic [CW-1:0]        nact,
	input  qrrs_pkg::gf_t        gen_row [MAX_ECC],
	input  logic                 busy,
	output logic                 load,
	output qrrs_pkg::gf_t        rem_next [MAX_ECC]
);

	logic           vld_s1;
	logic [7:0]     data_s1;
	logic           last_s1;
	qrrs_pkg::gf_t  rem_q [MAX_ECC];
	qrrs_pkg::gf_t  fb;
	logic           adv;

	// Input stage stalls only when a last beat waits for the drain buffer
	assign adv = !(last_s1 && busy);
	assign s_tready = !vld_s1 || adv;
	assign load = vld_s1 && last_s1 && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Feedback and shifted remainder; entries at or above the count hold
	assign fb = data_s1 ^ rem_q[IW'(nact - CW'(1))];

	always_comb begin
		for (int j = 0; j < MAX_ECC; j++) begin
			if (j >= int'(nact)) begin
				rem_next[j] = rem_q[j];
			end else if (j == 0) begin
				rem_next[j] = qrrs_pkg::gf_mul(fb, gen_row[j]);
			end else begin
				rem_next[j] = rem_q[j-1] ^ qrrs_pkg::gf_mul(fb, gen_row[j]);
			end
		end
	end

	// Remainder register, cleared after the last beat of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_ECC; j++) begin
				rem_q[j] <= 8'h00;
			end
		end else if (vld_s1 && adv) begin
			for (int j = 0; j < MAX_ECC; j++) begin
				rem_q[j] <= last_s1 ? 8'h00 : rem_next[j];
			end
		end
	end

endmodule

/* hdl/qrrs_drain.sv */
// ----------------------------------------------------------------------------
// qrrs_drain - check-byte output buffer
// Holds a finished remainder and sends it highest degree first.
// ----------------------------------------------------------------------------
module qrrs_drain #(
	parameter int MAX_ECC = 30,
	localparam int CW = $clog2(MAX_ECC + 1),
	localparam int IW = $clog2(MAX_ECC)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  qrrs_pkg::gf_t        ld_data [MAX_ECC],
	input  logic [CW-1:0]        ld_cnt,
	output logic                 busy,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast
);

	qrrs_pkg::gf_t  buf_q [MAX_ECC];
	logic [CW-1:0]  cnt_q;

	// Bytes left to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ld_cnt;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= ld_data;
		end
	end

	assign busy = (cnt_q != '0);
	assign m_tvalid = busy;
	assign m_tdata = buf_q[IW'(cnt_q - CW'(1))];
	assign m_tlast = (cnt_q == CW'(1));

endmodule

/* hdl/qr_reed_solomon_ecc_encoder.sv */
// ----------------------------------------------------------------------------
// qr_reed_solomon_ecc_encoder - QR Reed-Solomon check-byte encoder, GF(256)
// Systematic: data bytes in, ecc_count check bytes (2..MAX_ECC) out per block.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)  tuser  tlast
//  s_       in   data_byte[7:0]      -      last_byte
//  m_       out  ecc_byte[7:0]       -      last_ecc
//  apb      in   ecc_count at 0x0 (bits 4:0)
//
//  One data beat per cycle while the input is not stalled; a taken beat passes
//  through the input register, then the divider update into the remainder.
//  A block's check bytes appear the cycle after its last beat is processed
//  and leave one per cycle, held by the output buffer while m_tready is low.
//  A last beat waits in the input register while the previous block's check
//  bytes still drain; non-last beats keep flowing meanwhile.
//  Reset clears the remainder and sets ecc_count to 10.
// ----------------------------------------------------------------------------
module qr_reed_solomon_ecc_encoder #(
	parameter int MAX_ECC = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	// data beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	// check beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] ecc_byte
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_ECC + 1);

	logic [CW-1:0]  nact;
	qrrs_pkg::gf_t  gen_row [MAX_ECC];
	qrrs_pkg::gf_t  rem_next [MAX_ECC];
	logic           load;
	logic           busy;

	qrrs_cfg #(.MAX_ECC(MAX_ECC)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.nact    (nact),
		.gen_row (gen_row)
	);

	qrrs_lfsr #(.MAX_ECC(MAX_ECC)) u_lfsr (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.nact     (nact),
		.gen_row  (gen_row),
		.busy     (busy),
		.load     (load),
		.rem_next (rem_next)
	);

	qrrs_drain #(.MAX_ECC(MAX_ECC)) u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.ld_data  (rem_next),
		.ld_cnt   (nact),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// A block is never handed over while the buffer still holds one
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && busy))
		else $error("remainder loaded while check bytes still draining");

	// A handed-over block shows up at the output on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("check bytes missing after load");

	// Input stalls only while the output buffer is busy
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> busy)
		else $error("input stalled with idle output buffer");

endmodule
